[src/sorted_key_table_macros.svh]
// ----------------------------------------------------------------------------
// sorted_key_table assertion macros
// Concurrent assertion wrappers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_TABLE_MACROS_SVH
`define SORTED_KEY_TABLE_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset.
`define SKT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define SKT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SKT_ASSERT(lbl, clk, rstn, prop, msg)
`define SKT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[src/skt_pkg.sv]
// ----------------------------------------------------------------------------
// skt_pkg
// Shared types and constants of the sorted key table.
// ----------------------------------------------------------------------------
`default_nettype none

package skt_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned CNTO_W   = 7;

  typedef enum logic [FUNC_W-1:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_FIND   = 3'd2,
    OP_ANY    = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_BS_RD,
    S_BS_CMP,
    S_CHK,
    S_DEL_RD,
    S_DEL_WR,
    S_ANY_RD,
    S_ANY_CMP,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] phone;
    logic [KEY_W-1:0] addr;
  } entry_t;

  localparam int unsigned ENT_W = $bits(entry_t);

  // Flags from the shared compare unit
  typedef struct packed {
    logic key_lt;
    logic key_gt;
    logic key_eq;
    logic any_eq;
  } cmp_t;

endpackage

`default_nettype wire

[src/skt_ram.sv]
// ----------------------------------------------------------------------------
// skt_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module skt_ram #(
  parameter int unsigned DEPTH = 2,
  parameter int unsigned WIDTH = 8,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[src/skt_cmp.sv]
// ----------------------------------------------------------------------------
// skt_cmp
// Shared compare unit: orders a stored key against the search key and
// matches any field of the entry against a search value.
// ----------------------------------------------------------------------------
`default_nettype none

module skt_cmp import skt_pkg::*; (
  input  entry_t           entry_i,
  input  logic [KEY_W-1:0] key_i,
  input  logic [KEY_W-1:0] value_i,
  output cmp_t             cmp_o
);

  always_comb begin
    cmp_o.key_lt = entry_i.key < key_i;
    cmp_o.key_gt = entry_i.key > key_i;
    cmp_o.key_eq = entry_i.key == key_i;
    cmp_o.any_eq = (entry_i.key == value_i) || (entry_i.phone == value_i) ||
                   (entry_i.addr == value_i);
  end

endmodule

`default_nettype wire

[src/sorted_key_table.sv]
// ----------------------------------------------------------------------------
// sorted_key_table
// Sorted table of key/phone/address entries with insert, delete, lookups and clear.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake                  | Payload
//  --------+----------------------------+---------------------------------------
//  in      | in_valid_i / in_ready_o    | func, name_key, phone_word,
//          |                            | address_word, search_value
//  out     | out_valid_o / out_ready_i  | ok, status, position, entry_count_out,
//          |                            | found_name, found_phone, found_address
//
//  One item at a time; a sequencer drives one RAM port pair and one compare unit.
//  Insert shifts each larger entry up from the end, find is a binary search,
//  delete is the find plus shifting the later entries down one place, find
//  any scans entries from position zero; clear and unused codes touch no RAM.
//  Each search or insert step is one RAM read then one compare; each delete
//  shift step is one read then one write. Reset empties the table at once
//  (count to zero, no clearing pass). A stalled result sits in the output
//  register while the next transfer is taken; the sequencer only waits if it finishes before that result leaves.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sorted_key_table_macros.svh"

module sorted_key_table import skt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [FUNC_W-1:0] func_i,
  input  logic [KEY_W-1:0]  name_key_i,
  input  logic [KEY_W-1:0]  phone_word_i,
  input  logic [KEY_W-1:0]  address_word_i,
  input  logic [KEY_W-1:0]  search_value_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              ok_o,
  output logic [1:0]        status_o,
  output logic [POS_W-1:0]  position_o,
  output logic [CNTO_W-1:0] entry_count_out_o,
  output logic [KEY_W-1:0]  found_name_o,
  output logic [KEY_W-1:0]  found_phone_o,
  output logic [KEY_W-1:0]  found_address_o
);

  // Sequencer state and working registers
  state_e            state_q, state_d;
  logic [FUNC_W-1:0] op_q, op_d;
  entry_t            ent_q, ent_d;        // key/payload in flight, then result entry
  logic [KEY_W-1:0]  sval_q, sval_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  lo_q, lo_d;
  logic [CNT_W-1:0]  hi_q, hi_d;

  // Pending result
  logic              res_ok_q, res_ok_d;
  status_e           res_st_q, res_st_d;
  logic [CNT_W-1:0]  res_pos_q, res_pos_d;
  logic              res_hit_q, res_hit_d;

  // Output register
  logic              out_valid_q, out_valid_d;
  logic              ok_q, ok_d;
  status_e           status_q, status_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [CNTO_W-1:0] cnt_out_q, cnt_out_d;
  entry_t            found_q, found_d;

  // RAM port and compare unit
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  entry_t            ram_wdata;
  logic [ENT_W-1:0]  rd_word;
  entry_t            rd_entry;
  cmp_t              cmp;

  logic [CNT_W-1:0]  mid, idx_dec, idx_inc;
  logic              accept, full, resp_go, wr_state;

  assign accept  = in_valid_i && in_ready_o;
  assign full    = count_q == CNT_W'(CAPACITY);
  assign mid     = lo_q + ((hi_q - lo_q) >> 1);
  assign idx_dec = idx_q - CNT_W'(1);
  assign idx_inc = idx_q + CNT_W'(1);
  assign resp_go = !out_valid_q || out_ready_i;
  assign rd_entry = entry_t'(rd_word);
  // states that may write the RAM
  assign wr_state = (state_q == S_INS_RD) || (state_q == S_INS_CMP) ||
                    (state_q == S_DEL_WR);

  skt_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (ENT_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rd_word)
  );

  skt_cmp u_cmp (
    .entry_i (rd_entry),
    .key_i   (ent_q.key),
    .value_i (sval_q),
    .cmp_o   (cmp)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (func_i)
            OP_INSERT: state_d = full ? S_RESP : S_INS_RD;
            OP_DELETE: state_d = S_BS_RD;
            OP_FIND:   state_d = S_BS_RD;
            OP_ANY:    state_d = S_ANY_RD;
            default:   state_d = S_RESP;
          endcase
        end
      end
      S_INS_RD:  state_d = (idx_q == '0) ? S_RESP : S_INS_CMP;
      S_INS_CMP: state_d = cmp.key_gt ? S_INS_RD : S_RESP;
      S_BS_RD: begin
        if (lo_q < hi_q) begin
          state_d = S_BS_CMP;
        end else if (lo_q < count_q) begin
          state_d = S_CHK;
        end else begin
          state_d = S_RESP;
        end
      end
      S_BS_CMP: state_d = S_BS_RD;
      S_CHK: begin
        if (cmp.key_eq && op_q == OP_DELETE) begin
          state_d = S_DEL_RD;
        end else begin
          state_d = S_RESP;
        end
      end
      S_DEL_RD:  state_d = (idx_inc < count_q) ? S_DEL_WR : S_RESP;
      S_DEL_WR:  state_d = S_DEL_RD;
      S_ANY_RD:  state_d = (idx_q < count_q) ? S_ANY_CMP : S_RESP;
      S_ANY_CMP: state_d = cmp.any_eq ? S_RESP : S_ANY_RD;
      S_RESP:    state_d = resp_go ? S_IDLE : S_RESP;
      default:   state_d = S_IDLE;
    endcase
  end

  // Datapath, RAM control and result composition
  always_comb begin
    op_d        = op_q;
    ent_d       = ent_q;
    sval_d      = sval_q;
    count_d     = count_q;
    idx_d       = idx_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    res_ok_d    = res_ok_q;
    res_st_d    = res_st_q;
    res_pos_d   = res_pos_q;
    res_hit_d   = res_hit_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ok_d        = ok_q;
    status_d    = status_q;
    pos_d       = pos_q;
    cnt_out_d   = cnt_out_q;
    found_d     = found_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = '0;
    ram_raddr   = '0;
    ram_wdata   = ent_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d      = func_i;
          ent_d     = '{key: name_key_i, phone: phone_word_i, addr: address_word_i};
          sval_d    = search_value_i;
          lo_d      = '0;
          hi_d      = count_q;
          idx_d     = (func_i == OP_INSERT) ? count_q : '0;
          res_ok_d  = 1'b0;
          res_st_d  = ST_OK;
          res_pos_d = '0;
          res_hit_d = 1'b0;
          case (func_i)
            OP_INSERT: begin
              if (full) begin
                res_st_d = ST_FULL;
              end
            end
            OP_CLEAR: begin
              count_d  = '0;
              res_ok_d = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_INS_RD: begin
        if (idx_q == '0) begin
          // reached the bottom: place the new entry at zero
          ram_we    = 1'b1;
          ram_waddr = '0;
          count_d   = count_q + CNT_W'(1);
          res_ok_d  = 1'b1;
          res_pos_d = '0;
          res_hit_d = 1'b1;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = idx_dec[AW-1:0];
        end
      end
      S_INS_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q[AW-1:0];
        if (cmp.key_gt) begin
          // move the larger entry up one place
          ram_wdata = rd_entry;
          idx_d     = idx_dec;
        end else begin
          count_d   = count_q + CNT_W'(1);
          res_ok_d  = 1'b1;
          res_pos_d = idx_q;
          res_hit_d = 1'b1;
        end
      end
      S_BS_RD: begin
        if (lo_q < hi_q) begin
          ram_re    = 1'b1;
          ram_raddr = mid[AW-1:0];
          idx_d     = mid;
        end else if (lo_q < count_q) begin
          ram_re    = 1'b1;
          ram_raddr = lo_q[AW-1:0];
        end else begin
          res_st_d = ST_MISS;
        end
      end
      S_BS_CMP: begin
        if (cmp.key_lt) begin
          lo_d = idx_inc;
        end else begin
          hi_d = idx_q;
        end
      end
      S_CHK: begin
        if (cmp.key_eq) begin
          ent_d     = rd_entry;
          res_ok_d  = 1'b1;
          res_pos_d = lo_q;
          res_hit_d = 1'b1;
          idx_d     = lo_q;
        end else begin
          res_st_d = ST_MISS;
        end
      end
      S_DEL_RD: begin
        if (idx_inc < count_q) begin
          ram_re    = 1'b1;
          ram_raddr = idx_inc[AW-1:0];
        end else begin
          count_d = count_q - CNT_W'(1);
        end
      end
      S_DEL_WR: begin
        // close the gap one entry at a time
        ram_we    = 1'b1;
        ram_waddr = idx_q[AW-1:0];
        ram_wdata = rd_entry;
        idx_d     = idx_inc;
      end
      S_ANY_RD: begin
        if (idx_q < count_q) begin
          ram_re    = 1'b1;
          ram_raddr = idx_q[AW-1:0];
        end else begin
          res_st_d = ST_MISS;
        end
      end
      S_ANY_CMP: begin
        if (cmp.any_eq) begin
          ent_d     = rd_entry;
          res_ok_d  = 1'b1;
          res_pos_d = idx_q;
          res_hit_d = 1'b1;
        end else begin
          idx_d = idx_inc;
        end
      end
      S_RESP: begin
        if (resp_go) begin
          out_valid_d = 1'b1;
          ok_d        = res_ok_q;
          status_d    = res_st_q;
          pos_d       = POS_W'(res_pos_q);
          cnt_out_d   = CNTO_W'(count_q);
          found_d     = res_hit_q ? ent_q : '0;
        end
      end
      default: begin
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    ent_q     <= ent_d;
    sval_q    <= sval_d;
    idx_q     <= idx_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    res_ok_q  <= res_ok_d;
    res_st_q  <= res_st_d;
    res_pos_q <= res_pos_d;
    res_hit_q <= res_hit_d;
    ok_q      <= ok_d;
    status_q  <= status_d;
    pos_q     <= pos_d;
    cnt_out_q <= cnt_out_d;
    found_q   <= found_d;
  end

  assign in_ready_o        = state_q == S_IDLE;
  assign out_valid_o       = out_valid_q;
  assign ok_o              = ok_q;
  assign status_o          = status_q;
  assign position_o        = pos_q;
  assign entry_count_out_o = cnt_out_q;
  assign found_name_o      = found_q.key;
  assign found_phone_o     = found_q.phone;
  assign found_address_o   = found_q.addr;

  // Assertions
  `SKT_ASSERT(a_count_max, clk_i, rst_ni, count_q <= CNT_W'(CAPACITY), "count above capacity")
  `SKT_ASSERT(a_read_valid, clk_i, rst_ni, ram_re |-> CNT_W'(ram_raddr) < count_q, "read past end")
  `SKT_ASSERT(a_write_state, clk_i, rst_ni, ram_we |-> wr_state, "write outside a shift")
  `SKT_ASSERT(a_clear_empty, clk_i, rst_ni, accept && func_i == OP_CLEAR |=> count_q == '0, "clear")
  `SKT_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |=> (!out_valid_o && !ram_we), "busy in reset")

endmodule

`default_nettype wire

[verif/sorted_key_table_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_table_tb
// Self-checking bench for the sorted key table. A directed pass covers empty,
// duplicate, miss, clear and unused-code cases. Random phases with weighted
// operations follow, under several sender and receiver idle patterns. A
// scoreboard keeps its own sorted copy of the table and checks every result
// field by field.
// ----------------------------------------------------------------------------
module sorted_key_table_tb import skt_pkg::*; ();

  localparam int unsigned CLK_HALF     = 2;
  localparam int unsigned RESET_CYCLES = 10;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  // Slowest operation scans or shifts all entries.
  localparam int unsigned TAIL_CYCLES  = 4 * CAPACITY;
  localparam int unsigned POOL_SIZE    = 16;

  // func codes the block does not use
  localparam logic [FUNC_W-1:0] OP_UNUSED_LO = 3'd5;
  localparam logic [FUNC_W-1:0] OP_UNUSED_HI = 3'd7;

  localparam logic [KEY_W-1:0] KEY_ZERO = {KEY_W{1'b0}};
  localparam logic [KEY_W-1:0] KEY_ONES = {KEY_W{1'b1}};
  // Packed names: "MARIA" and "JOAO", zero-padded, big-endian
  localparam logic [KEY_W-1:0] NAME_MARIA = 64'h4D41_5249_4100_0000;
  localparam logic [KEY_W-1:0] NAME_JOAO  = 64'h4A4F_414F_0000_0000;

  typedef struct {
    logic               ok;
    status_e            status;
    logic [POS_W-1:0]   position;
    logic [CNTO_W-1:0]  count;
    logic [KEY_W-1:0]   name;
    logic [KEY_W-1:0]   phone;
    logic [KEY_W-1:0]   addr;
  } table_result_t;

  // Mirror of the table plus the queue of results still owed by the block.
  class key_table_scoreboard;
    logic [KEY_W-1:0] key_mem   [CAPACITY];
    logic [KEY_W-1:0] phone_mem [CAPACITY];
    logic [KEY_W-1:0] addr_mem  [CAPACITY];
    int unsigned      entry_count;
    table_result_t    owed_q[$];
    int unsigned      errors;

    function new();
      entry_count = 0;
      errors      = 0;
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    function table_result_t hit_result(int unsigned idx);
      table_result_t r;
      r.ok       = 1'b1;
      r.status   = ST_OK;
      r.position = POS_W'(idx);
      r.count    = '0;
      r.name     = key_mem[idx];
      r.phone    = phone_mem[idx];
      r.addr     = addr_mem[idx];
      return r;
    endfunction

    // Table is sorted, so the first equal key is the lowest matching position.
    function int unsigned first_key(logic [KEY_W-1:0] key);
      for (int unsigned i = 0; i < entry_count; i++) begin
        if (key_mem[i] == key) return i;
      end
      return entry_count;
    endfunction

    function void note_input(logic [FUNC_W-1:0] func, logic [KEY_W-1:0] key,
                             logic [KEY_W-1:0] phone, logic [KEY_W-1:0] addr,
                             logic [KEY_W-1:0] value);
      table_result_t r;
      int unsigned   idx;
      r = '{ok: 1'b0, status: ST_OK, position: '0, count: '0,
            name: '0, phone: '0, addr: '0};
      case (func)
        OP_INSERT: begin
          if (entry_count >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            idx = entry_count;
            while (idx > 0 && key_mem[idx-1] > key) begin
              key_mem[idx]   = key_mem[idx-1];
              phone_mem[idx] = phone_mem[idx-1];
              addr_mem[idx]  = addr_mem[idx-1];
              idx--;
            end
            key_mem[idx]   = key;
            phone_mem[idx] = phone;
            addr_mem[idx]  = addr;
            entry_count++;
            r = hit_result(idx);
          end
        end
        OP_DELETE: begin
          idx = first_key(key);
          if (idx < entry_count) begin
            r = hit_result(idx);
            for (int unsigned i = idx; i + 1 < entry_count; i++) begin
              key_mem[i]   = key_mem[i+1];
              phone_mem[i] = phone_mem[i+1];
              addr_mem[i]  = addr_mem[i+1];
            end
            entry_count--;
          end else begin
            r.status = ST_MISS;
          end
        end
        OP_FIND: begin
          idx = first_key(key);
          if (idx < entry_count) r = hit_result(idx);
          else r.status = ST_MISS;
        end
        OP_ANY: begin
          idx = 0;
          while (idx < entry_count && key_mem[idx] != value &&
                 phone_mem[idx] != value && addr_mem[idx] != value) idx++;
          if (idx < entry_count) r = hit_result(idx);
          else r.status = ST_MISS;
        end
        OP_CLEAR: begin
          entry_count = 0;
          r.ok        = 1'b1;
        end
        default: begin
        end
      endcase
      r.count = CNTO_W'(entry_count);
      owed_q.push_back(r);
    endfunction

    function void compare_field(string field, logic [KEY_W-1:0] exp_v,
                                logic [KEY_W-1:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected %0h, actual %0h", field, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(table_result_t got);
      table_result_t exp_r;
      if (owed_q.size() == 0) begin
        $error("result with no operation outstanding");
        errors++;
        return;
      end
      exp_r = owed_q.pop_front();
      compare_field("ok", KEY_W'(exp_r.ok), KEY_W'(got.ok));
      compare_field("status", KEY_W'(exp_r.status), KEY_W'(got.status));
      compare_field("position", KEY_W'(exp_r.position), KEY_W'(got.position));
      compare_field("entry_count_out", KEY_W'(exp_r.count), KEY_W'(got.count));
      compare_field("found_name", exp_r.name, got.name);
      compare_field("found_phone", exp_r.phone, got.phone);
      compare_field("found_address", exp_r.addr, got.addr);
    endfunction
  endclass

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              in_valid_i     = 1'b0;
  logic              in_ready_o;
  logic [FUNC_W-1:0] func_i         = '0;
  logic [KEY_W-1:0]  name_key_i     = '0;
  logic [KEY_W-1:0]  phone_word_i   = '0;
  logic [KEY_W-1:0]  address_word_i = '0;
  logic [KEY_W-1:0]  search_value_i = '0;
  logic              out_valid_o;
  logic              out_ready_i    = 1'b0;
  logic              ok_o;
  logic [1:0]        status_o;
  logic [POS_W-1:0]  position_o;
  logic [CNTO_W-1:0] entry_count_out_o;
  logic [KEY_W-1:0]  found_name_o;
  logic [KEY_W-1:0]  found_phone_o;
  logic [KEY_W-1:0]  found_address_o;

  key_table_scoreboard sb = new();

  // Percent chance per cycle that the sender holds off / the receiver stalls
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int unsigned cycle_cnt = 0;

  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  sorted_key_table u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .func_i            (func_i),
    .name_key_i        (name_key_i),
    .phone_word_i      (phone_word_i),
    .address_word_i    (address_word_i),
    .search_value_i    (search_value_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .ok_o              (ok_o),
    .status_o          (status_o),
    .position_o        (position_o),
    .entry_count_out_o (entry_count_out_o),
    .found_name_o      (found_name_o),
    .found_phone_o     (found_phone_o),
    .found_address_o   (found_address_o)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // Hard stop in case the block hangs.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side: everything is stable at the falling edge, so a handshake
  // seen here is the transfer of the next rising edge.
  always @(negedge clk_i) begin
    table_result_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.ok       = ok_o;
      got.status   = status_e'(status_o);
      got.position = position_o;
      got.count    = entry_count_out_o;
      got.name     = found_name_o;
      got.phone    = found_phone_o;
      got.addr     = found_address_o;
      sb.check_result(got);
    end
  end

  // Pick the next cycle's ready.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  function automatic logic [KEY_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Bias keys toward ones already stored so deletes and finds mostly hit,
  // and toward a small pool so duplicates pile up.
  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 5 && sb.entry_count > 0) return sb.key_mem[$urandom_range(sb.entry_count - 1)];
    if (r < 8) return key_pool[$urandom_range(POOL_SIZE - 1)];
    if (r == 8) return $urandom_range(1) ? KEY_ONES : KEY_ZERO;
    return rand_word();
  endfunction

  // Mostly pull a search value from one of the three fields of a stored entry, else from the pool or a random word.
  function automatic logic [KEY_W-1:0] pick_search();
    int unsigned idx;
    if (sb.entry_count > 0 && $urandom_range(9) < 7) begin
      idx = $urandom_range(sb.entry_count - 1);
      case ($urandom_range(2))
        0:       return sb.key_mem[idx];
        1:       return sb.phone_mem[idx];
        default: return sb.addr_mem[idx];
      endcase
    end
    return $urandom_range(1) ? key_pool[$urandom_range(POOL_SIZE - 1)] : rand_word();
  endfunction

  // Weights are percentages; whatever is left over goes to unused codes.
  function automatic logic [FUNC_W-1:0] pick_op(int unsigned w_ins, int unsigned w_del,
                                                int unsigned w_fnd, int unsigned w_any,
                                                int unsigned w_clr);
    int unsigned r;
    r = $urandom_range(99);
    if (r < w_ins) return OP_INSERT;
    r -= w_ins;
    if (r < w_del) return OP_DELETE;
    r -= w_del;
    if (r < w_fnd) return OP_FIND;
    r -= w_fnd;
    if (r < w_any) return OP_ANY;
    r -= w_any;
    if (r < w_clr) return OP_CLEAR;
    return FUNC_W'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
  endfunction

  // Call at a rising edge. Hold valid and payload until the transfer, then
  // hand the item to the scoreboard.
  task automatic send_item(input logic [FUNC_W-1:0] func, input logic [KEY_W-1:0] key,
                           input logic [KEY_W-1:0] phone, input logic [KEY_W-1:0] addr,
                           input logic [KEY_W-1:0] value);
    logic rdy;
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    in_valid_i     <= 1'b1;
    func_i         <= func;
    name_key_i     <= key;
    phone_word_i   <= phone;
    address_word_i <= addr;
    search_value_i <= value;
    // Ready seen at the falling edge holds through the next rising edge.
    do begin
      @(negedge clk_i);
      rdy = in_ready_o;
      @(posedge clk_i);
    end while (!rdy);
    sb.note_input(func, key, phone, addr, value);
  endtask

  // Drop valid and hold off until every owed result has come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic run_phase(int unsigned items, int unsigned snd_idle, int unsigned rcv_stall,
                           int unsigned w_ins, int unsigned w_del, int unsigned w_fnd,
                           int unsigned w_any, int unsigned w_clr);
    int unsigned      done;
    logic [FUNC_W-1:0] func;
    idle_pct  = snd_idle;
    stall_pct = rcv_stall;
    done      = 0;
    while (done < items) begin
      func = pick_op(w_ins, w_del, w_fnd, w_any, w_clr);
      send_item(func, pick_key(), rand_word(), rand_word(), pick_search());
      // Unused codes do nothing, so do not count them.
      if (func <= OP_CLEAR) done++;
    end
    drain();
  endtask

  initial begin
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = rand_word();
    key_pool[0] = NAME_MARIA;
    key_pool[1] = NAME_JOAO;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every search on an empty table misses.
    send_item(OP_FIND,   NAME_MARIA, KEY_ZERO, KEY_ZERO, KEY_ZERO);
    send_item(OP_ANY,    KEY_ZERO,   KEY_ZERO, KEY_ZERO, KEY_ZERO);
    send_item(OP_DELETE, KEY_ONES,   KEY_ZERO, KEY_ZERO, KEY_ONES);
    // Key extremes, then an insert that lands in the middle.
    send_item(OP_INSERT, KEY_ONES,   KEY_ONES, KEY_ONES, KEY_ZERO);
    send_item(OP_INSERT, KEY_ZERO,   KEY_ZERO, KEY_ZERO, KEY_ZERO);
    send_item(OP_INSERT, NAME_MARIA, 64'h1111, 64'h2222, KEY_ZERO);
    // Duplicate key goes after the existing one; finds hit the first.
    send_item(OP_INSERT, NAME_MARIA, 64'h3333, 64'h4444, KEY_ZERO);
    send_item(OP_INSERT, NAME_JOAO,  64'h5555, 64'h6666, KEY_ZERO);
    send_item(OP_FIND,   NAME_MARIA, KEY_ZERO, KEY_ZERO, KEY_ZERO);
    send_item(OP_FIND,   KEY_ONES,   KEY_ZERO, KEY_ZERO, KEY_ZERO);
    send_item(OP_ANY,    KEY_ZERO,   KEY_ZERO, KEY_ZERO, 64'h3333);
    send_item(OP_ANY,    KEY_ZERO,   KEY_ZERO, KEY_ZERO, 64'h6666);
    send_item(OP_ANY,    KEY_ZERO,   KEY_ZERO, KEY_ZERO, NAME_JOAO);
    send_item(OP_ANY,    KEY_ZERO,   KEY_ZERO, KEY_ZERO, 64'h7777);
    send_item(OP_DELETE, NAME_MARIA, KEY_ZERO, KEY_ZERO, KEY_ZERO);
    send_item(OP_FIND,   NAME_MARIA, KEY_ZERO, KEY_ZERO, KEY_ZERO);
    send_item(OP_DELETE, 64'h1,      KEY_ZERO, KEY_ZERO, KEY_ZERO);
    send_item(OP_DELETE, KEY_ONES,   KEY_ZERO, KEY_ZERO, KEY_ZERO);
    // Unused codes leave the table alone.
    for (logic [FUNC_W:0] f = {1'b0, OP_UNUSED_LO}; f <= {1'b0, OP_UNUSED_HI}; f++) begin
      send_item(f[FUNC_W-1:0], KEY_ONES, KEY_ONES, KEY_ONES, KEY_ONES);
    end
    send_item(OP_CLEAR,  KEY_ZERO,   KEY_ZERO, KEY_ZERO, KEY_ZERO);
    send_item(OP_FIND,   KEY_ZERO,   KEY_ZERO, KEY_ZERO, KEY_ZERO);
    drain();

    // Random: first fill past capacity with no idling, then mixed traffic
    // under sender idling, receiver stalls, and both together.
    run_phase(200,  0,  0, 75,  5,  8,  8, 0);
    run_phase(200, 84,  0, 35, 20, 20, 17, 3);
    run_phase(200,  0, 84, 35, 20, 20, 17, 3);
    run_phase(200, 23, 23, 45, 15, 17, 17, 3);

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
